### src/fco_pkg.sv
// Package for the feathered circle overlay: constants, register indexes and the
// payload and settings structs used by the overlay modules.
// Depends on nothing.
package fco_pkg;

    localparam int unsigned MAX_DIM = 1024;

    // Field widths.
    localparam int unsigned COORD_W = 10;
    localparam int unsigned PT_W    = COORD_W + 1;
    localparam int unsigned SQ_W    = 2 * PT_W;
    localparam int unsigned D2_W    = SQ_W + 1;
    localparam int unsigned R2_W    = 2 * COORD_W;
    localparam int unsigned NUM_W   = R2_W + 8;
    localparam int unsigned Q_W     = 8;
    localparam int unsigned CFG_W   = 10;
    localparam int unsigned IDX_W   = 3;

    // Sample kinds.
    localparam logic FUNC_LUMA   = 1'b0;
    localparam logic FUNC_CHROMA = 1'b1;

    // Register indexes.
    localparam logic [IDX_W-1:0] REG_CENTER_X   = 3'd0;
    localparam logic [IDX_W-1:0] REG_CENTER_Y   = 3'd1;
    localparam logic [IDX_W-1:0] REG_RADIUS     = 3'd2;
    localparam logic [IDX_W-1:0] REG_FEATHER    = 3'd3;
    localparam logic [IDX_W-1:0] REG_FILL_RED   = 3'd4;
    localparam logic [IDX_W-1:0] REG_FILL_GREEN = 3'd5;
    localparam logic [IDX_W-1:0] REG_FILL_BLUE  = 3'd6;

    typedef struct packed {
        logic               func;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        logic [7:0]         sample_a;
        logic [7:0]         sample_b;
    } pixel_in_t;

    typedef struct packed {
        logic [7:0] result_a;
        logic [7:0] result_b;
        logic       covered;
    } pixel_out_t;

    // Settings and values derived from them; the user must hold them steady while samples flow.
    typedef struct packed {
        logic [COORD_W-1:0] center_x;
        logic [COORD_W-1:0] center_y;
        logic [R2_W-1:0]    r2;
        logic [R2_W-1:0]    inner2;
        logic [R2_W-1:0]    den;
        logic [7:0]         fill_y;
        logic [7:0]         fill_u;
        logic [7:0]         fill_v;
    } cfg_t;

    // Geometry result handed to the divider.
    typedef struct packed {
        logic             func;
        logic [7:0]       sample_a;
        logic [7:0]       sample_b;
        logic             covered;
        logic [NUM_W-1:0] num;
    } geom_out_t;

    // One divider stage: partial remainder and quotient bits so far.
    typedef struct packed {
        logic             func;
        logic [7:0]       sample_a;
        logic [7:0]       sample_b;
        logic             covered;
        logic [NUM_W-1:0] rem;
        logic [Q_W-1:0]   quot;
    } div_stage_t;

endpackage

### src/fco_config.sv
// Configuration register file for the circle overlay, plus the two register
// stages that derive squared radii, the ring divisor and the fill colour in YUV.
// Depends on fco_pkg.
module fco_config
    import fco_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    output cfg_t               cfg
);

    logic [COORD_W-1:0] center_x_reg, center_y_reg, radius_reg, feather_reg;
    logic [7:0]         red_reg, green_reg, blue_reg;

    logic [R2_W-1:0]    r2_reg, r2_next;
    logic [R2_W-1:0]    inner2_reg, inner2_next;
    logic [R2_W-1:0]    den_reg, den_next;
    logic [15:0]        ysum_reg, ysum_next;
    logic [15:0]        usum_reg, usum_next;
    logic [15:0]        vsum_reg, vsum_next;
    logic [7:0]         fy_reg, fy_next;
    logic [7:0]         fu_reg, fu_next;
    logic [7:0]         fv_reg, fv_next;
    logic [COORD_W:0]   inner;

    function automatic logic [7:0] sat255(input logic [8:0] v);
        return (v > 9'd255) ? 8'd255 : v[7:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            radius_reg   <= '0;
            feather_reg  <= '0;
            red_reg      <= '0;
            green_reg    <= '0;
            blue_reg     <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_CENTER_X:   center_x_reg <= cfg_data[COORD_W-1:0];
                REG_CENTER_Y:   center_y_reg <= cfg_data[COORD_W-1:0];
                REG_RADIUS:     radius_reg   <= cfg_data[COORD_W-1:0];
                REG_FEATHER:    feather_reg  <= cfg_data[COORD_W-1:0];
                REG_FILL_RED:   red_reg      <= cfg_data[7:0];
                REG_FILL_GREEN: green_reg    <= cfg_data[7:0];
                REG_FILL_BLUE:  blue_reg     <= cfg_data[7:0];
                default:        ;
            endcase
        end
    end

    // First derived stage: squares and the colour sums.
    always_comb
    begin
        inner       = {1'b0, radius_reg} - {1'b0, feather_reg};
        r2_next     = R2_W'(radius_reg) * R2_W'(radius_reg);
        inner2_next = '0;
        if (!inner[COORD_W] && inner != '0)
        begin
            inner2_next = R2_W'(inner[COORD_W-1:0]) * R2_W'(inner[COORD_W-1:0]);
        end
        ysum_next = 16'd66 * 16'(red_reg) + 16'd129 * 16'(green_reg)
                  + 16'd25 * 16'(blue_reg) + 16'd128;
        // The offset keeps these sums positive for every colour.
        usum_next = 16'd112 * 16'(blue_reg) + 16'd32896
                  - 16'd38 * 16'(red_reg) - 16'd74 * 16'(green_reg);
        vsum_next = 16'd112 * 16'(red_reg) + 16'd32896
                  - 16'd94 * 16'(green_reg) - 16'd18 * 16'(blue_reg);
    end

    // Second derived stage: the ring divisor and the clamped fill colour.
    always_comb
    begin
        den_next = r2_reg - inner2_reg + R2_W'(1);
        fy_next  = sat255(9'(ysum_reg[15:8]) + 9'd16);
        fu_next  = sat255(9'(usum_reg[15:8]));
        fv_next  = sat255(9'(vsum_reg[15:8]));
    end

    // Reset values are those derived from all-zero settings, so the block is
    // usable straight after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r2_reg     <= '0;
            inner2_reg <= '0;
            ysum_reg   <= 16'd128;
            usum_reg   <= 16'd32896;
            vsum_reg   <= 16'd32896;
            den_reg    <= R2_W'(1);
            fy_reg     <= 8'd16;
            fu_reg     <= 8'd128;
            fv_reg     <= 8'd128;
        end
        else
        begin
            r2_reg     <= r2_next;
            inner2_reg <= inner2_next;
            ysum_reg   <= ysum_next;
            usum_reg   <= usum_next;
            vsum_reg   <= vsum_next;
            den_reg    <= den_next;
            fy_reg     <= fy_next;
            fu_reg     <= fu_next;
            fv_reg     <= fv_next;
        end
    end

    always_comb
    begin
        cfg.center_x = center_x_reg;
        cfg.center_y = center_y_reg;
        cfg.r2       = r2_reg;
        cfg.inner2   = inner2_reg;
        cfg.den      = den_reg;
        cfg.fill_y   = fy_reg;
        cfg.fill_u   = fu_reg;
        cfg.fill_v   = fv_reg;
    end

endmodule

### src/fco_geom.sv
// Four-stage geometry pipeline: sample point, squared distance, circle and ring
// tests, and the scaled ring offset that feeds the divider.
// Depends on fco_pkg.
module fco_geom
    import fco_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      in_valid,
    output logic      in_ready,
    input  pixel_in_t in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output geom_out_t out_data
);

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    // Stage 1: distances along each axis.
    logic            func1_reg;
    logic [7:0]      sa1_reg, sb1_reg;
    logic            frame1_reg, frame1_next;
    logic [PT_W-1:0] adx1_reg, adx1_next, ady1_reg, ady1_next;
    logic [PT_W-1:0] x_pt, y_pt, cx_pt, cy_pt;

    // Stage 2: squares.
    logic            func2_reg, frame2_reg;
    logic [7:0]      sa2_reg, sb2_reg;
    logic [SQ_W-1:0] sqx2_reg, sqx2_next, sqy2_reg, sqy2_next;

    // Stage 3: distance and tests.
    logic            func3_reg;
    logic [7:0]      sa3_reg, sb3_reg;
    logic [D2_W-1:0] d2_3_reg, d2_3_next;
    logic            inside3_reg, inside3_next, ring3_reg, ring3_next;

    // Stage 4: numerator of the ring fraction.
    geom_out_t       s4_reg, s4_next;
    logic [R2_W-1:0] diff;

    assign en4      = !v4_reg || out_ready;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    always_comb
    begin
        cx_pt = {1'b0, cfg.center_x};
        cy_pt = {1'b0, cfg.center_y};
        if (in_data.func == FUNC_CHROMA)
        begin
            // A chroma pair is sampled at (column+1, 2*row+1).
            x_pt        = {1'b0, in_data.column} + PT_W'(1);
            y_pt        = {in_data.row, 1'b1};
            frame1_next = (32'(in_data.row) < MAX_DIM / 2)
                       && (32'(in_data.column) + 32'd1 < MAX_DIM);
        end
        else
        begin
            x_pt        = {1'b0, in_data.column};
            y_pt        = {1'b0, in_data.row};
            frame1_next = (32'(in_data.column) < MAX_DIM) && (32'(in_data.row) < MAX_DIM);
        end
        adx1_next = (x_pt >= cx_pt) ? x_pt - cx_pt : cx_pt - x_pt;
        ady1_next = (y_pt >= cy_pt) ? y_pt - cy_pt : cy_pt - y_pt;
    end

    always_comb
    begin
        sqx2_next = SQ_W'(adx1_reg) * SQ_W'(adx1_reg);
        sqy2_next = SQ_W'(ady1_reg) * SQ_W'(ady1_reg);
    end

    always_comb
    begin
        d2_3_next    = D2_W'(sqx2_reg) + D2_W'(sqy2_reg);
        inside3_next = frame2_reg && (d2_3_next <= D2_W'(cfg.r2));
        ring3_next   = d2_3_next > D2_W'(cfg.inner2);
    end

    always_comb
    begin
        // Inside the circle the distance never exceeds r2, so it fits R2_W bits.
        diff              = R2_W'(d2_3_reg - D2_W'(cfg.inner2));
        s4_next.func      = func3_reg;
        s4_next.sample_a  = sa3_reg;
        s4_next.sample_b  = sb3_reg;
        s4_next.covered   = inside3_reg;
        s4_next.num       = '0;
        if (inside3_reg && ring3_reg && func3_reg == FUNC_LUMA)
        begin
            s4_next.num = (NUM_W'(diff) << 8) - NUM_W'(diff);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            func1_reg  <= in_data.func;
            sa1_reg    <= in_data.sample_a;
            sb1_reg    <= in_data.sample_b;
            frame1_reg <= frame1_next;
            adx1_reg   <= adx1_next;
            ady1_reg   <= ady1_next;
        end
        if (en2)
        begin
            func2_reg  <= func1_reg;
            sa2_reg    <= sa1_reg;
            sb2_reg    <= sb1_reg;
            frame2_reg <= frame1_reg;
            sqx2_reg   <= sqx2_next;
            sqy2_reg   <= sqy2_next;
        end
        if (en3)
        begin
            func3_reg   <= func2_reg;
            sa3_reg     <= sa2_reg;
            sb3_reg     <= sb2_reg;
            d2_3_reg    <= d2_3_next;
            inside3_reg <= inside3_next;
            ring3_reg   <= ring3_next;
        end
        if (en4)
        begin
            s4_reg <= s4_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_data  = s4_reg;

endmodule

### src/fco_div.sv
// Pipelined restoring divider, one quotient bit per stage, for the feather
// fraction. The quotient is known to stay below 255. Depends on fco_pkg.
module fco_div
    import fco_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [R2_W-1:0] den,
    input  logic       in_valid,
    output logic       in_ready,
    input  geom_out_t  in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output div_stage_t out_data
);

    div_stage_t st_reg [Q_W];
    div_stage_t st_in  [Q_W];
    logic       v_reg  [Q_W];
    logic       en     [Q_W+1];

    always_comb
    begin
        en[Q_W] = out_ready;
        for (int k = Q_W - 1; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign in_ready = en[0];

    always_comb
    begin
        st_in[0].func     = in_data.func;
        st_in[0].sample_a = in_data.sample_a;
        st_in[0].sample_b = in_data.sample_b;
        st_in[0].covered  = in_data.covered;
        st_in[0].rem      = in_data.num;
        st_in[0].quot     = '0;
    end

    for (genvar k = 0; k < Q_W; k++)
    begin : g_stage
        logic [NUM_W-1:0] dshift;
        div_stage_t       nxt;
        logic             v_in;

        if (k > 0)
        begin : g_link
            assign st_in[k] = st_reg[k-1];
            assign v_in     = v_reg[k-1];
        end
        else
        begin : g_head
            assign v_in = in_valid;
        end

        // Stage k decides quotient bit Q_W-1-k.
        always_comb
        begin
            dshift = NUM_W'(den) << (Q_W - 1 - k);
            nxt    = st_in[k];
            if (st_in[k].rem >= dshift)
            begin
                nxt.rem               = st_in[k].rem - dshift;
                nxt.quot[Q_W - 1 - k] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en[k])
            begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                st_reg[k] <= nxt;
            end
        end
    end

    assign out_valid = v_reg[Q_W-1];
    assign out_data  = st_reg[Q_W-1];

endmodule

### src/fco_blend.sv
// Two-stage blend and output register: weights the old luma against the fill
// luma, divides by 255 and selects the result fields. Depends on fco_pkg.
module fco_blend
    import fco_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       in_valid,
    output logic       in_ready,
    input  div_stage_t in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output pixel_out_t out_data
);

    logic        v1_reg, v2_reg;
    logic        en1, en2;
    logic        func1_reg, cov1_reg;
    logic [7:0]  sa1_reg, sb1_reg;
    logic [15:0] mix1_reg, mix1_next;
    logic [15:0] corr;
    pixel_out_t  out_reg, out_next;

    assign en2      = !v2_reg || out_ready;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    // The quotient is 255 minus alpha, so it weights the old sample.
    always_comb
    begin
        mix1_next = 16'(in_data.sample_a) * 16'(in_data.quot)
                  + 16'(cfg.fill_y) * 16'(8'd255 - in_data.quot);
    end

    // Exact division by 255 for values below 65280.
    always_comb
    begin
        corr              = mix1_reg + 16'd1 + (mix1_reg >> 8);
        out_next.result_a = sa1_reg;
        out_next.result_b = sb1_reg;
        out_next.covered  = cov1_reg;
        if (cov1_reg)
        begin
            if (func1_reg == FUNC_CHROMA)
            begin
                out_next.result_a = cfg.fill_u;
                out_next.result_b = cfg.fill_v;
            end
            else
            begin
                out_next.result_a = corr[15:8];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            func1_reg <= in_data.func;
            cov1_reg  <= in_data.covered;
            sa1_reg   <= in_data.sample_a;
            sb1_reg   <= in_data.sample_b;
            mix1_reg  <= mix1_next;
        end
        if (en2)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_data  = out_reg;

endmodule

### src/feathered_circle_overlay_nv12_top.sv
// Feathered circle overlay for NV12 video: ties the register file to the
// geometry, divider and blend pipelines. Depends on fco_pkg and all fco_ modules.
//
// Usage: samples enter on in_valid/in_ready/in_data, one beat per luma sample
// (func 0) or per interleaved chroma pair (func 1), and leave on
// out_valid/out_ready/out_data in the same order, one result beat per sample.
// The settings port is a plain write: cfg_write high for one cycle stores
// cfg_data into the register chosen by cfg_index (0 centre x, 1 centre y,
// 2 radius, 3 feather, 4 to 6 red, green, blue); indexes beyond are ignored.
// Write settings only while no beats are in flight.
// Each accepted input beat passes four geometry stages, eight divider stages
// (one quotient bit each) and two blend stages, the last being the output
// register. Throughput is one beat per cycle while the receiver does not stall.
// Every stage holds its own valid bit, so when the receiver stalls the
// pipeline fills its empty stages first and in_ready drops only once the
// stalled result is backed up to the input stage; nothing is lost or repeated.
// Reset clears all settings to zero and empties the pipeline; derived values
// (squared radii, fill colour in YUV) follow the settings through registers.
module feathered_circle_overlay_nv12_top
    import fco_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             in_valid,
    output logic             in_ready,
    input  pixel_in_t        in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output pixel_out_t       out_data
);

    cfg_t       cfg;
    logic       geom_valid, geom_ready;
    geom_out_t  geom_data;
    logic       div_valid, div_ready;
    div_stage_t div_data;

    fco_config u_config (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    fco_geom u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (geom_valid),
        .out_ready (geom_ready),
        .out_data  (geom_data)
    );

    fco_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .den       (cfg.den),
        .in_valid  (geom_valid),
        .in_ready  (geom_ready),
        .in_data   (geom_data),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_data  (div_data)
    );

    fco_blend u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (div_valid),
        .in_ready  (div_ready),
        .in_data   (div_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
